// ===== sv/ilid_pkg.sv =====
// shared types, codes and command/status structs for the indexed list
`timescale 1ns / 1ps
`default_nettype none
package ilid_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   localparam logic [2:0] REQ_CLEAR  = 3'd0;
   localparam logic [2:0] REQ_APPEND = 3'd1;
   localparam logic [2:0] REQ_INSERT = 3'd2;
   localparam logic [2:0] REQ_DELETE = 3'd3;
   localparam logic [2:0] REQ_READ   = 3'd4;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_FULL       = 3'd1;
   localparam logic [2:0] ST_EMPTY      = 3'd2;
   localparam logic [2:0] ST_BADPOS     = 3'd3;
   localparam logic [2:0] ST_NOTCREATED = 3'd4;

   localparam logic [2:0] ACT_NONE   = 3'd0;
   localparam logic [2:0] ACT_CLEAR  = 3'd1;
   localparam logic [2:0] ACT_APPEND = 3'd2;
   localparam logic [2:0] ACT_INSERT = 3'd3;
   localparam logic [2:0] ACT_DELETE = 3'd4;
   localparam logic [2:0] ACT_READ   = 3'd5;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [7:0]         position;
      logic signed [31:0] value;
   } ilid_req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] data_out;
      logic [7:0]         count;
   } ilid_rsp_type;

   typedef struct packed {
      logic load;
      logic decide;
      logic clear;
      logic append;
      logic ins_start;
      logic ins_step_rd;
      logic ins_step_wr;
      logic ins_final;
      logic del_start;
      logic del_step_rd;
      logic del_step_wr;
      logic del_final;
      logic rd_start;
      logic capture;
   } ilid_cmd_type;

   typedef struct packed {
      logic [2:0] action;
      logic       k_at_pos;
      logic       k_at_end;
   } ilid_sts_type;

endpackage
`default_nettype wire

// ===== sv/indexed_list_insert_delete.sv =====
// top level of the indexed list with insert and delete at a position
`timescale 1ns / 1ps
`default_nettype none
// An item is taken when start is high and busy is low; busy then stays high
// until its result has been shown. Every item gives exactly one result, held
// on rsp_item for the single cycle in which rsp_valid is high; the receiver
// cannot hold it off, so it must take it then. The list lives in a
// single-port-write, registered-read memory of CAPACITY entries, and insert
// and delete move the following entries one at a time through that port, a
// read and then a write per entry. A new item can be started in the cycle
// after its result. The memory needs no clearing after reset.
module indexed_list_insert_delete #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                        busy,
   input  wire ilid_pkg::ilid_req_type req_item,
   output logic                        rsp_valid,
   output ilid_pkg::ilid_rsp_type      rsp_item
);
   import ilid_pkg::*;

   ilid_cmd_type cmd;
   ilid_sts_type sts;

   ilid_control u_control (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   ilid_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_item (rsp_item)
   );

endmodule
`default_nettype wire

// ===== sv/ilid_datapath.sv =====
// list storage, fill count, request checks and shift index
`timescale 1ns / 1ps
`default_nettype none
module ilid_datapath #(
   parameter int CAPACITY = ilid_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire ilid_pkg::ilid_req_type req_item,
   input  wire ilid_pkg::ilid_cmd_type cmd,
   output ilid_pkg::ilid_sts_type      sts,
   output ilid_pkg::ilid_rsp_type      rsp_item
);
   import ilid_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 8) ? CW : 8;

   logic signed [31:0] mem [CAPACITY];
   logic signed [31:0] rdata_ff;

   ilid_req_type       req_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic               created_ff, created_in;
   logic [CW-1:0]      k_ff, k_in;
   logic [2:0]         status_ff, status_in;
   logic signed [31:0] data_ff, data_in;

   logic [PW-1:0]      pos_wide, cnt_wide;
   logic [CW-1:0]      pos_cnt, pos_m1;
   logic [CW:0]        k_p1;
   logic               full;
   logic [2:0]         dec_action, dec_status;

   logic               rd_en, wr_en;
   logic [CW-1:0]      rd_idx, wr_idx;
   logic signed [31:0] wr_data;

   assign pos_wide = PW'(req_ff.position);
   assign cnt_wide = PW'(count_ff);
   assign pos_cnt  = pos_wide[CW-1:0];
   assign pos_m1   = pos_cnt - CW'(1);
   assign k_p1     = {1'b0, k_ff} + (CW+1)'(1);
   assign full     = (count_ff == CW'(CAPACITY));

   always_comb begin
      dec_action = ACT_NONE;
      dec_status = ST_OK;
      unique case (req_ff.req_type)
         REQ_CLEAR: begin
            dec_action = ACT_CLEAR;
         end
         REQ_APPEND: begin
            if (full) begin
               dec_status = ST_FULL;
            end else begin
               dec_action = ACT_APPEND;
            end
         end
         REQ_INSERT: begin
            if (!created_ff) begin
               dec_status = ST_NOTCREATED;
            end else if (full) begin
               dec_status = ST_FULL;
            end else if (pos_wide > cnt_wide) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_action = ACT_INSERT;
            end
         end
         REQ_DELETE: begin
            if (!created_ff) begin
               dec_status = ST_NOTCREATED;
            end else if (count_ff == '0) begin
               dec_status = ST_EMPTY;
            end else if (pos_wide == '0 || pos_wide > cnt_wide) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_action = ACT_DELETE;
            end
         end
         REQ_READ: begin
            if (!created_ff) begin
               dec_status = ST_NOTCREATED;
            end else if (count_ff == '0) begin
               dec_status = ST_EMPTY;
            end else if (pos_wide >= cnt_wide) begin
               dec_status = ST_BADPOS;
            end else begin
               dec_action = ACT_READ;
            end
         end
         default: begin
            dec_status = ST_BADPOS;
         end
      endcase
   end

   assign sts.action   = dec_action;
   assign sts.k_at_pos = (k_ff == pos_cnt);
   assign sts.k_at_end = (k_p1 >= {1'b0, count_ff});

   // memory port selection
   always_comb begin
      rd_en   = cmd.del_start | cmd.ins_step_rd | cmd.del_step_rd | cmd.rd_start;
      rd_idx  = pos_cnt;
      if (cmd.del_start) begin
         rd_idx = pos_m1;
      end else if (cmd.ins_step_rd) begin
         rd_idx = k_ff - CW'(1);
      end else if (cmd.del_step_rd) begin
         rd_idx = k_p1[CW-1:0];
      end
      wr_en   = cmd.append | cmd.ins_step_wr | cmd.ins_final | cmd.del_step_wr;
      wr_idx  = k_ff;
      wr_data = rdata_ff;
      if (cmd.append) begin
         wr_idx  = count_ff;
         wr_data = req_ff.value;
      end else if (cmd.ins_final) begin
         wr_idx  = pos_cnt;
         wr_data = req_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rdata_ff <= mem[rd_idx[AW-1:0]];
      end
      if (wr_en) begin
         mem[wr_idx[AW-1:0]] <= wr_data;
      end
   end

   always_comb begin
      count_in   = count_ff;
      created_in = created_ff;
      k_in       = k_ff;
      status_in  = status_ff;
      data_in    = data_ff;
      if (cmd.decide) begin
         status_in = dec_status;
         data_in   = '0;
         if (req_ff.req_type == REQ_CLEAR || req_ff.req_type == REQ_APPEND) begin
            created_in = 1'b1;
         end
      end
      if (cmd.clear) begin
         count_in = '0;
      end
      if (cmd.append || cmd.ins_final) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.del_final) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.ins_start) begin
         k_in = count_ff;
      end
      if (cmd.del_start) begin
         k_in = pos_m1;
      end
      if (cmd.ins_step_wr) begin
         k_in = k_ff - CW'(1);
      end
      if (cmd.del_step_wr) begin
         k_in = k_ff + CW'(1);
      end
      if (cmd.capture) begin
         data_in = rdata_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         created_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         created_ff <= created_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_item;
      end
      k_ff      <= k_in;
      status_ff <= status_in;
      data_ff   <= data_in;
   end

   assign rsp_item.status   = status_ff;
   assign rsp_item.data_out = data_ff;
   assign rsp_item.count    = cnt_wide[7:0];

endmodule
`default_nettype wire

// ===== sv/ilid_control.sv =====
// request sequencer: checks, entry shifting steps and result strobe
`timescale 1ns / 1ps
`default_nettype none
module ilid_control (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire ilid_pkg::ilid_sts_type sts,
   output ilid_pkg::ilid_cmd_type      cmd,
   output logic                        busy,
   output logic                        rsp_valid
);
   import ilid_pkg::*;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_CHECK   = 3'd1;
   localparam logic [2:0] S_INS_RD  = 3'd2;
   localparam logic [2:0] S_INS_WR  = 3'd3;
   localparam logic [2:0] S_DEL_CAP = 3'd4;
   localparam logic [2:0] S_DEL_RD  = 3'd5;
   localparam logic [2:0] S_DEL_WR  = 3'd6;
   localparam logic [2:0] S_DONE    = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rd_cap_ff, rd_cap_in;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      rd_cap_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            cmd.decide = 1'b1;
            state_in   = S_DONE;
            unique case (sts.action)
               ACT_CLEAR:  cmd.clear  = 1'b1;
               ACT_APPEND: cmd.append = 1'b1;
               ACT_INSERT: begin
                  cmd.ins_start = 1'b1;
                  state_in      = S_INS_RD;
               end
               ACT_DELETE: begin
                  cmd.del_start = 1'b1;
                  state_in      = S_DEL_CAP;
               end
               ACT_READ: begin
                  cmd.rd_start = 1'b1;
                  rd_cap_in    = 1'b1;
                  state_in     = S_DEL_CAP;
               end
               default: begin
               end
            endcase
         end
         S_INS_RD: begin
            if (sts.k_at_pos) begin
               cmd.ins_final = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.ins_step_rd = 1'b1;
               state_in        = S_INS_WR;
            end
         end
         S_INS_WR: begin
            cmd.ins_step_wr = 1'b1;
            state_in        = S_INS_RD;
         end
         S_DEL_CAP: begin
            cmd.capture = 1'b1;
            state_in    = rd_cap_ff ? S_DONE : S_DEL_RD;
         end
         S_DEL_RD: begin
            if (sts.k_at_end) begin
               cmd.del_final = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.del_step_rd = 1'b1;
               state_in        = S_DEL_WR;
            end
         end
         S_DEL_WR: begin
            cmd.del_step_wr = 1'b1;
            state_in        = S_DEL_RD;
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rd_cap_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_cap_ff <= rd_cap_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

endmodule
`default_nettype wire

// ===== tb/tb_indexed_list_insert_delete.sv =====
// self-checking testbench for the indexed list: directed table, then phased random traffic
`timescale 1ns / 1ps
module tb_indexed_list_insert_delete;
   import ilid_pkg::*;

   localparam int CAPACITY = CAPACITY_DEFAULT;

   localparam logic [2:0] REQ_SPARE_A = 3'd5;
   localparam logic [2:0] REQ_SPARE_B = 3'd6;
   localparam logic [2:0] REQ_SPARE_C = 3'd7;

   typedef enum int {PH_GROW, PH_SHRINK, PH_MIXED} phase_kind_type;

   typedef struct packed {
      ilid_req_type req;
      bit           typed;
      ilid_rsp_type rsp;
   } script_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   ilid_req_type req_item;
   logic         rsp_valid;
   ilid_rsp_type rsp_item;

   logic [31:0]  shadow_cells [CAPACITY];
   int           shadow_count = 0;
   bit           shadow_created = 1'b0;

   ilid_rsp_type awaited_rsp [$];
   int           fault_count = 0;
   int           steady_left = 0;

   script_row_type script [25] = '{
      '{'{REQ_READ,    8'd0,   32'sd0},          1'b1, '{ST_NOTCREATED, 32'sd0, 8'd0}},
      '{'{REQ_INSERT,  8'd0,   32'sd5},          1'b1, '{ST_NOTCREATED, 32'sd0, 8'd0}},
      '{'{REQ_DELETE,  8'd1,   32'sd0},          1'b1, '{ST_NOTCREATED, 32'sd0, 8'd0}},
      '{'{REQ_SPARE_B, 8'd0,   32'sd0},          1'b1, '{ST_BADPOS,     32'sd0, 8'd0}},
      '{'{REQ_DELETE,  8'd0,   32'sd0},          1'b1, '{ST_NOTCREATED, 32'sd0, 8'd0}},
      '{'{REQ_CLEAR,   8'd0,   32'sd0},          1'b1, '{ST_OK,         32'sd0, 8'd0}},
      '{'{REQ_READ,    8'd0,   32'sd0},          1'b1, '{ST_EMPTY,      32'sd0, 8'd0}},
      '{'{REQ_DELETE,  8'd1,   32'sd0},          1'b1, '{ST_EMPTY,      32'sd0, 8'd0}},
      '{'{REQ_INSERT,  8'd1,   32'sd9},          1'b1, '{ST_BADPOS,     32'sd0, 8'd0}},
      '{'{REQ_INSERT,  8'd0,   32'sh8000_0000},  1'b1, '{ST_OK,         32'sd0, 8'd1}},
      '{'{REQ_APPEND,  8'd0,   32'sh7fff_ffff},  1'b1, '{ST_OK,         32'sd0, 8'd2}},
      '{'{REQ_DELETE,  8'd0,   32'sd0},          1'b1, '{ST_BADPOS,     32'sd0, 8'd2}},
      '{'{REQ_DELETE,  8'd3,   32'sd0},          1'b1, '{ST_BADPOS,     32'sd0, 8'd2}},
      '{'{REQ_READ,    8'd2,   32'sd0},          1'b1, '{ST_BADPOS,     32'sd0, 8'd2}},
      '{'{REQ_READ,    8'd0,   32'sd0},          1'b1, '{ST_OK, 32'sh8000_0000, 8'd2}},
      '{'{REQ_READ,    8'd1,   32'sd0},          1'b1, '{ST_OK, 32'sh7fff_ffff, 8'd2}},
      '{'{REQ_INSERT,  8'd2,   32'shffff_ffff},  1'b0, '{ST_OK,         32'sd0, 8'd0}},
      '{'{REQ_INSERT,  8'd1,   32'sd0},          1'b0, '{ST_OK,         32'sd0, 8'd0}},
      '{'{REQ_DELETE,  8'd4,   32'sd0},          1'b1, '{ST_OK, 32'shffff_ffff, 8'd3}},
      '{'{REQ_DELETE,  8'd1,   32'sd0},          1'b1, '{ST_OK, 32'sh8000_0000, 8'd2}},
      '{'{REQ_READ,    8'd255, 32'sd0},          1'b1, '{ST_BADPOS,     32'sd0, 8'd2}},
      '{'{REQ_SPARE_A, 8'd255, 32'shffff_ffff},  1'b1, '{ST_BADPOS,     32'sd0, 8'd2}},
      '{'{REQ_SPARE_C, 8'd128, 32'sh5a5a_a5a5},  1'b1, '{ST_BADPOS,     32'sd0, 8'd2}},
      '{'{REQ_READ,    8'd1,   32'sd0},          1'b0, '{ST_OK,         32'sd0, 8'd0}},
      '{'{REQ_INSERT,  8'd255, 32'sd3},          1'b1, '{ST_BADPOS,     32'sd0, 8'd2}}
   };

   indexed_list_insert_delete u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic ilid_rsp_type predict_list_request(input ilid_req_type r);
      ilid_rsp_type res;
      int p;
      p = int'(r.position);
      res.status = ST_OK;
      res.data_out = '0;
      case (r.req_type)
         REQ_CLEAR: begin
            shadow_count = 0;
            shadow_created = 1'b1;
         end
         REQ_APPEND: begin
            shadow_created = 1'b1;
            if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else begin
               shadow_cells[shadow_count] = r.value;
               shadow_count++;
            end
         end
         REQ_INSERT: begin
            if (!shadow_created) begin
               res.status = ST_NOTCREATED;
            end else if (shadow_count >= CAPACITY) begin
               res.status = ST_FULL;
            end else if (p > shadow_count) begin
               res.status = ST_BADPOS;
            end else begin
               for (int k = shadow_count; k > p; k--) shadow_cells[k] = shadow_cells[k - 1];
               shadow_cells[p] = r.value;
               shadow_count++;
            end
         end
         REQ_DELETE: begin
            if (!shadow_created) begin
               res.status = ST_NOTCREATED;
            end else if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else if (p == 0 || p > shadow_count) begin
               res.status = ST_BADPOS;
            end else begin
               res.data_out = shadow_cells[p - 1];
               for (int k = p - 1; k + 1 < shadow_count; k++) shadow_cells[k] = shadow_cells[k + 1];
               shadow_count--;
            end
         end
         REQ_READ: begin
            if (!shadow_created) begin
               res.status = ST_NOTCREATED;
            end else if (shadow_count == 0) begin
               res.status = ST_EMPTY;
            end else if (p >= shadow_count) begin
               res.status = ST_BADPOS;
            end else begin
               res.data_out = shadow_cells[p];
            end
         end
         default: res.status = ST_BADPOS;
      endcase
      res.count = 8'(shadow_count);
      return res;
   endfunction

   function automatic int pick_gap();
      int roll;
      if (steady_left > 0) begin
         steady_left--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         steady_left = $urandom_range(20, 80);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // mostly legal positions, some on the edges, the rest anywhere in the byte
   function automatic logic [7:0] pick_position(input int lo, input int hi);
      int roll;
      roll = $urandom_range(0, 99);
      if (hi >= lo && roll < 75) return 8'($urandom_range(hi, lo));
      if (roll < 88) begin
         case ($urandom_range(0, 3))
            0: return 8'(lo);
            1: return 8'(hi);
            2: return 8'(hi + 1);
            default: return 8'(lo - 1);
         endcase
      end
      return 8'($urandom);
   endfunction

   function automatic ilid_req_type random_request(input phase_kind_type ph);
      ilid_req_type r;
      int roll;
      roll = $urandom_range(0, 199);
      r.value = random_value();
      if (ph != PH_GROW && roll < 3) begin
         r.req_type = REQ_CLEAR;
      end else if (roll >= 3 && roll < 7) begin
         r.req_type = REQ_READ + 3'($urandom_range(1, 3));
      end else begin
         roll = $urandom_range(0, 99);
         case (ph)
            PH_GROW: r.req_type = roll < 50 ? REQ_APPEND : roll < 85 ? REQ_INSERT :
                                  roll < 93 ? REQ_READ : REQ_DELETE;
            PH_SHRINK: r.req_type = roll < 55 ? REQ_DELETE : roll < 75 ? REQ_READ :
                                    roll < 90 ? REQ_INSERT : REQ_APPEND;
            default: r.req_type = roll < 20 ? REQ_APPEND : roll < 45 ? REQ_INSERT :
                                  roll < 70 ? REQ_DELETE : REQ_READ;
         endcase
      end
      case (r.req_type)
         REQ_INSERT: r.position = pick_position(0, shadow_count);
         REQ_DELETE: r.position = pick_position(1, shadow_count);
         REQ_READ:   r.position = pick_position(0, shadow_count - 1);
         default:    r.position = 8'($urandom);
      endcase
      return r;
   endfunction

   task automatic issue_request(input ilid_req_type r, input bit typed, input ilid_rsp_type fixed);
      ilid_rsp_type predicted;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= r;
      do @(posedge clock); while (busy);
      predicted = predict_list_request(r);
      awaited_rsp.push_back(typed ? fixed : predicted);
   endtask

   always @(posedge clock) begin : check_results
      ilid_rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected result, expected none, got status %0d data %h count %0d",
                     $time, rsp_item.status, rsp_item.data_out, rsp_item.count);
            fault_count++;
         end else begin
            want = awaited_rsp.pop_front();
            if (rsp_item.status !== want.status) begin
               $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_item.status);
               fault_count++;
            end
            if (rsp_item.data_out !== want.data_out) begin
               $display("%0t: data_out expected %h, got %h", $time, want.data_out,
                        rsp_item.data_out);
               fault_count++;
            end
            if (rsp_item.count !== want.count) begin
               $display("%0t: count expected %0d, got %0d", $time, want.count, rsp_item.count);
               fault_count++;
            end
         end
      end
   end

   initial begin
      phase_kind_type ph;
      int phase_left;
      int waited;
      start <= 1'b0;
      req_item <= '0;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < $size(script); i++) begin
         issue_request(script[i].req, script[i].typed, script[i].rsp);
      end
      // first phase mostly grows the list with appends and inserts
      ph = PH_GROW;
      phase_left = 220;
      for (int i = 0; i < 1525; i++) begin
         if (phase_left == 0) begin
            ph = phase_kind_type'($urandom_range(0, 2));
            phase_left = $urandom_range(40, 220);
         end
         phase_left--;
         issue_request(random_request(ph), 1'b0, '0);
      end
      start <= 1'b0;
      waited = 0;
      while (awaited_rsp.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (awaited_rsp.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, awaited_rsp.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #25_000_000;
      $display("%0t: timeout", $time);
      $display("simulation failed");
      $finish;
   end

endmodule

// ===== indexed_list_insert_delete.f =====
sv/ilid_pkg.sv
sv/ilid_datapath.sv
sv/ilid_control.sv
sv/indexed_list_insert_delete.sv
tb/tb_indexed_list_insert_delete.sv
